[design/ubxd_pkg.sv]
// ----------------------------------------------------------------------------
// ubxd_pkg
// Shared types and constants of the binary frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ubxd_pkg;

    localparam int DEF_MAX_FRAME_PAYLOAD = 1024;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam int MAXP_W = 11;
    localparam logic [MAXP_W-1:0] MAXP_RESET = 11'd1024;

    // register index on the configuration port
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_CK_BAD   = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG = 2'd3;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic [9:0]  byte_index;
        logic [7:0]  payload_byte;
        logic        last;
    } ubxd_item_t;

endpackage

`default_nettype wire

[design/ubxd_front.sv]
// ----------------------------------------------------------------------------
// ubxd_front
// Byte parser: sync hunt, header capture, length check, checksum, result build.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxd_front
    import ubxd_pkg::*;
#(
    parameter int MAX_FRAME_PAYLOAD = DEF_MAX_FRAME_PAYLOAD
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [MAXP_W-1:0] max_payload,
    output logic                   push,
    output ubxd_item_t             item
);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B
    } phase_t;

    localparam logic [15:0] MAX_LIMIT = 16'(MAX_FRAME_PAYLOAD);

    phase_t            phase_reg, phase_next;
    logic [7:0]        cur_class_reg, cur_class_next;
    logic [7:0]        cur_id_reg, cur_id_next;
    logic [15:0]       cur_length_reg, cur_length_next;
    logic [MAXP_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0]        sum_a_reg, sum_a_next;
    logic [7:0]        sum_b_reg, sum_b_next;
    logic [7:0]        got_check_a_reg, got_check_a_next;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] len_full;
    logic [15:0] limit;
    logic [15:0] cfg_limit;

    assign add_a     = sum_a_reg + rx_byte;
    assign add_b     = sum_b_reg + add_a;
    assign len_full  = {rx_byte, cur_length_reg[7:0]};
    assign cfg_limit = {{(16-MAXP_W){1'b0}}, max_payload};
    assign limit     = (MAX_LIMIT < cfg_limit) ? MAX_LIMIT : cfg_limit;

    always_comb
    begin
        phase_next       = phase_reg;
        cur_class_next   = cur_class_reg;
        cur_id_next      = cur_id_reg;
        cur_length_next  = cur_length_reg;
        bytes_seen_next  = bytes_seen_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        got_check_a_next = got_check_a_reg;
        push             = 1'b0;
        item.kind         = KIND_PAYLOAD;
        item.byte_index   = 10'd0;
        item.payload_byte = 8'd0;
        item.last         = 1'b0;

        if (byte_valid)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        phase_next = PH_CLASS;
                        sum_a_next = 8'd0;
                        sum_b_next = 8'd0;
                    end
                    else if (rx_byte != SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_CLASS:
                begin
                    cur_class_next = rx_byte;
                    sum_a_next     = add_a;
                    sum_b_next     = add_b;
                    phase_next     = PH_ID;
                end
                PH_ID:
                begin
                    cur_id_next = rx_byte;
                    sum_a_next  = add_a;
                    sum_b_next  = add_b;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    cur_length_next = {8'd0, rx_byte};
                    sum_a_next      = add_a;
                    sum_b_next      = add_b;
                    phase_next      = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    cur_length_next = len_full;
                    sum_a_next      = add_a;
                    sum_b_next      = add_b;
                    bytes_seen_next = '0;
                    if (len_full > limit)
                    begin
                        // oversize frame: report and go back to hunting
                        phase_next = PH_HUNT;
                        push       = 1'b1;
                        item.kind  = KIND_TOO_LONG;
                        item.last  = 1'b1;
                    end
                    else if (len_full == 16'd0)
                    begin
                        phase_next = PH_CK_A;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    sum_a_next        = add_a;
                    sum_b_next        = add_b;
                    push              = 1'b1;
                    item.kind         = KIND_PAYLOAD;
                    item.byte_index   = bytes_seen_reg[9:0];
                    item.payload_byte = rx_byte;
                    bytes_seen_next   = bytes_seen_reg + 1'b1;
                    if ({{(16-MAXP_W){1'b0}}, bytes_seen_next} >= cur_length_reg)
                    begin
                        phase_next = PH_CK_A;
                    end
                end
                PH_CK_A:
                begin
                    got_check_a_next = rx_byte;
                    phase_next       = PH_CK_B;
                end
                PH_CK_B:
                begin
                    phase_next = PH_HUNT;
                    push       = 1'b1;
                    item.last  = 1'b1;
                    if ((got_check_a_reg == sum_a_reg) && (rx_byte == sum_b_reg))
                    begin
                        item.kind = KIND_GOOD;
                    end
                    else
                    begin
                        item.kind = KIND_CK_BAD;
                    end
                end
                default:
                begin
                    // hunting, and any code that means nothing
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end

        item.frame_class  = cur_class_next;
        item.frame_id     = cur_id_next;
        item.frame_length = cur_length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            cur_class_reg   <= '0;
            cur_id_reg      <= '0;
            cur_length_reg  <= '0;
            bytes_seen_reg  <= '0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            got_check_a_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            cur_class_reg   <= cur_class_next;
            cur_id_reg      <= cur_id_next;
            cur_length_reg  <= cur_length_next;
            bytes_seen_reg  <= bytes_seen_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            got_check_a_reg <= got_check_a_next;
        end
    end

endmodule

`default_nettype wire

[design/ubxd_queue.sv]
// ----------------------------------------------------------------------------
// ubxd_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxd_queue
    import ubxd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire ubxd_item_t  push_item,
    input  wire logic        pop,
    output ubxd_item_t       pop_item,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ubxd_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on write");

endmodule

`default_nettype wire

[design/ubxd_back.sv]
// ----------------------------------------------------------------------------
// ubxd_back
// Output stage: drains the queue into the registered output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxd_back
    import ubxd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  wire ubxd_item_t q_item,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output ubxd_item_t      out_item
);

    logic       out_valid_reg;
    ubxd_item_t out_item_reg;

    assign q_pop     = !q_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_item_reg <= q_item;
        end
    end

endmodule

`default_nettype wire

[design/ubx_frame_deframer_top.sv]
// an accepted byte's result is written into the queue, then into the output register for the master side
// throughput: one byte per cycle; results drain through a 4-entry queue
// s_tready drops only while that queue is full (output stalled)
// reset: parser hunts the first sync byte, checksum and header fields clear,
// max_payload returns to 1024
// ----------------------------------------------------------------------------
// ubx_frame_deframer_top
// Byte-stream frame parser with checksum check and an APB limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_frame_deframer_top
    import ubxd_pkg::*;
#(
    parameter int MAX_FRAME_PAYLOAD = DEF_MAX_FRAME_PAYLOAD
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    // result stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // frame_class, frame_id, frame_length,
                                        // byte_index, payload_byte, zero fill
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast
);

    logic [MAXP_W-1:0] max_payload_reg;
    logic              cfg_write;
    logic              byte_valid;
    logic              push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    ubxd_item_t        front_item;
    ubxd_item_t        q_item;
    ubxd_item_t        out_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_PAYLOAD);
    assign prdata    = (paddr[2] == REG_MAX_PAYLOAD) ?
                       {{(32-MAXP_W){1'b0}}, max_payload_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAXP_RESET;
        end
        else if (cfg_write)
        begin
            max_payload_reg <= pwdata[MAXP_W-1:0];
        end
    end

    assign s_tready   = !q_full;
    assign byte_valid = s_tvalid && s_tready;

    ubxd_front #(
        .MAX_FRAME_PAYLOAD(MAX_FRAME_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (s_tdata),
        .max_payload(max_payload_reg),
        .push       (push),
        .item       (front_item)
    );

    ubxd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(front_item),
        .pop      (q_pop),
        .pop_item (q_item),
        .full     (q_full),
        .empty    (q_empty)
    );

    ubxd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_item (out_item)
    );

    assign m_tdata = {6'd0, out_item.payload_byte, out_item.byte_index,
                      out_item.frame_length, out_item.frame_id, out_item.frame_class};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;

endmodule

`default_nettype wire
